FILE: sv/tpc_pkg.sv
package tpc_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned SPLIT_STEPS = 33;

  typedef logic [2:0][31:0] pos_t;

  typedef struct packed {
    pos_t        c;
    logic [31:0] d;
  } vertex_t;

  typedef enum logic [1:0] {
    MODE_ALL,
    MODE_ONE,
    MODE_TWO
  } mode_t;

  // ONE: splits (p0,p1) and (p0,p2). TWO: p0 = a, p1 = outside, p2 = b.
  typedef struct packed {
    mode_t   mode;
    vertex_t p0;
    vertex_t p1;
    vertex_t p2;
  } job_t;

  typedef struct packed {
    pos_t c0;
    pos_t c1;
    pos_t c2;
    logic last;
  } tri_t;

  typedef enum logic [1:0] {
    SP_IDLE,
    SP_MUL,
    SP_ADD,
    SP_DIV
  } split_st_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SPLIT,
    BK_EMIT
  } back_st_t;

endpackage

FILE: sv/tpc_front.sv
module tpc_front (
  input  logic               start,
  input  logic               full,
  input  tpc_pkg::vertex_t   v0,
  input  tpc_pkg::vertex_t   v1,
  input  tpc_pkg::vertex_t   v2,
  output logic               push,
  output tpc_pkg::job_t      job
);

  logic [2:0] ins;
  logic       keep;

  assign ins = {$signed(v2.d) > 0, $signed(v1.d) > 0, $signed(v0.d) > 0};

  always_comb begin
    keep     = 1'b1;
    job.mode = tpc_pkg::MODE_ALL;
    job.p0   = v0;
    job.p1   = v1;
    job.p2   = v2;
    case (ins)
      3'b111: job.mode = tpc_pkg::MODE_ALL;
      3'b001: job.mode = tpc_pkg::MODE_ONE;
      3'b010: begin
        job.mode = tpc_pkg::MODE_ONE;
        job.p0 = v1; job.p1 = v2; job.p2 = v0;
      end
      3'b100: begin
        job.mode = tpc_pkg::MODE_ONE;
        job.p0 = v2; job.p1 = v0; job.p2 = v1;
      end
      3'b110: begin
        job.mode = tpc_pkg::MODE_TWO;
        job.p0 = v2; job.p1 = v0; job.p2 = v1;
      end
      3'b101: job.mode = tpc_pkg::MODE_TWO;
      3'b011: begin
        job.mode = tpc_pkg::MODE_TWO;
        job.p0 = v1; job.p1 = v2; job.p2 = v0;
      end
      default: keep = 1'b0;
    endcase
  end

  assign push = start && !full && keep;

endmodule

FILE: sv/tpc_fifo.sv
module tpc_fifo #(
  parameter int unsigned DEPTH = tpc_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tpc_pkg::job_t wdata,
  input  logic          pop,
  output tpc_pkg::job_t rdata,
  output logic          empty,
  output logic          full
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  tpc_pkg::job_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign rdata = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: sv/tpc_split.sv
module tpc_split (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [31:0] pi,
  input  logic [31:0] pj,
  input  logic [31:0] di,
  input  logic [31:0] dj,
  output logic        done,
  output logic [31:0] res
);

  tpc_pkg::split_st_t st_r, st_nxt;
  logic [5:0]  cnt_r;
  logic        neg_r;
  logic [31:0] mag_r, den_r, pi_r, rem_r, res_r;
  logic [30:0] di_r;
  logic [62:0] prod_r;
  logic [32:0] nsh_r, q_r;
  logic        done_r;

  logic [32:0] diff, den_w, t, delta, q_fin;
  logic [63:0] num;
  logic        ge;

  assign diff  = {pj[31], pj} - {pi[31], pi};
  assign den_w = {di[31], di} - {dj[31], dj};
  assign num   = {1'b0, prod_r} + {33'd0, den_r[31:1]};
  assign t     = {rem_r, nsh_r[32]};
  assign ge    = (t >= {1'b0, den_r});
  assign q_fin = {q_r[31:0], ge};
  assign delta = neg_r ? (33'd0 - q_fin) : q_fin;

  assign done = done_r;
  assign res  = res_r;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      tpc_pkg::SP_IDLE: if (go) st_nxt = tpc_pkg::SP_MUL;
      tpc_pkg::SP_MUL:  st_nxt = tpc_pkg::SP_ADD;
      tpc_pkg::SP_ADD:  st_nxt = tpc_pkg::SP_DIV;
      tpc_pkg::SP_DIV: begin
        if (cnt_r == 6'(tpc_pkg::SPLIT_STEPS - 1)) st_nxt = tpc_pkg::SP_IDLE;
      end
      default: st_nxt = tpc_pkg::SP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= tpc_pkg::SP_IDLE;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      done_r <= (st_r == tpc_pkg::SP_DIV) && (st_nxt == tpc_pkg::SP_IDLE);
      cnt_r  <= (st_r == tpc_pkg::SP_DIV) ? cnt_r + 1'b1 : '0;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      tpc_pkg::SP_IDLE: begin
        neg_r <= diff[32];
        mag_r <= diff[32] ? 32'(33'd0 - diff) : diff[31:0];
        den_r <= den_w[31:0];
        di_r  <= di[30:0];
        pi_r  <= pi;
      end
      tpc_pkg::SP_MUL: prod_r <= mag_r * di_r;
      tpc_pkg::SP_ADD: begin
        rem_r <= {1'b0, num[63:33]};
        nsh_r <= num[32:0];
        q_r   <= '0;
      end
      tpc_pkg::SP_DIV: begin
        rem_r <= ge ? 32'(t - {1'b0, den_r}) : t[31:0];
        nsh_r <= {nsh_r[31:0], 1'b0};
        q_r   <= q_fin;
        res_r <= pi_r + delta[31:0];
      end
      default: ;
    endcase
  end

endmodule

FILE: sv/tpc_back.sv
module tpc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          empty,
  input  tpc_pkg::job_t job_in,
  output logic          pop,
  output logic          out_vld,
  output tpc_pkg::tri_t out_tri
);

  tpc_pkg::back_st_t st_r, st_nxt;
  tpc_pkg::job_t     job_r;
  logic [1:0]        idx_r, idx_nxt;
  logic              vld_r;
  tpc_pkg::tri_t     tri_r, tri_nxt;
  logic              go, emit;
  logic              go_r;
  logic [2:0]        done0, done1;
  tpc_pkg::pos_t     s0, s1, mid;
  tpc_pkg::vertex_t  src1;
  tpc_pkg::vertex_t  dst1;
  logic [32:0]       msum [3];

  assign src1 = (job_r.mode == tpc_pkg::MODE_TWO) ? job_r.p2 : job_r.p0;
  assign dst1 = (job_r.mode == tpc_pkg::MODE_TWO) ? job_r.p1 : job_r.p2;

  for (genvar k = 0; k < 3; k++) begin : g_axis
    tpc_split u_s0 (
      .clk(clk), .rst_n(rst_n), .go(go),
      .pi(job_r.p0.c[k]), .pj(job_r.p1.c[k]), .di(job_r.p0.d), .dj(job_r.p1.d),
      .done(done0[k]), .res(s0[k])
    );
    tpc_split u_s1 (
      .clk(clk), .rst_n(rst_n), .go(go),
      .pi(src1.c[k]), .pj(dst1.c[k]), .di(src1.d), .dj(dst1.d),
      .done(done1[k]), .res(s1[k])
    );
    assign msum[k] = {job_r.p0.c[k][31], job_r.p0.c[k]}
                   + {job_r.p2.c[k][31], job_r.p2.c[k]};
    assign mid[k]  = msum[k][32:1];
  end

  always_comb begin
    st_nxt  = st_r;
    idx_nxt = idx_r;
    pop     = 1'b0;
    emit    = 1'b0;
    tri_nxt = tri_r;
    case (st_r)
      tpc_pkg::BK_IDLE: begin
        if (!empty) begin
          pop     = 1'b1;
          idx_nxt = '0;
          if (job_in.mode == tpc_pkg::MODE_ALL) begin
            st_nxt = tpc_pkg::BK_EMIT;
          end else begin
            st_nxt = tpc_pkg::BK_SPLIT;
          end
        end
      end
      tpc_pkg::BK_SPLIT: if (&{done1, done0}) st_nxt = tpc_pkg::BK_EMIT;
      tpc_pkg::BK_EMIT: begin
        emit = 1'b1;
        tri_nxt.last = 1'b1;
        case (job_r.mode)
          tpc_pkg::MODE_ALL: begin
            tri_nxt.c0 = job_r.p0.c; tri_nxt.c1 = job_r.p1.c; tri_nxt.c2 = job_r.p2.c;
          end
          tpc_pkg::MODE_ONE: begin
            tri_nxt.c0 = job_r.p0.c; tri_nxt.c1 = s0; tri_nxt.c2 = s1;
          end
          default: begin
            tri_nxt.last = (idx_r == 2'd2);
            case (idx_r)
              2'd0: begin
                tri_nxt.c0 = job_r.p0.c; tri_nxt.c1 = s0; tri_nxt.c2 = mid;
              end
              2'd1: begin
                tri_nxt.c0 = mid; tri_nxt.c1 = s0; tri_nxt.c2 = s1;
              end
              default: begin
                tri_nxt.c0 = mid; tri_nxt.c1 = s1; tri_nxt.c2 = job_r.p2.c;
              end
            endcase
          end
        endcase
        if (tri_nxt.last) begin
          st_nxt = tpc_pkg::BK_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: st_nxt = tpc_pkg::BK_IDLE;
    endcase
  end

  // split units launch the cycle after the job is latched
  assign go = go_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= tpc_pkg::BK_IDLE;
      idx_r <= '0;
      vld_r <= 1'b0;
      go_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      idx_r <= idx_nxt;
      vld_r <= emit;
      go_r  <= pop && (job_in.mode != tpc_pkg::MODE_ALL);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= job_in;
    end
    tri_r <= tri_nxt;
  end

  assign out_vld = vld_r;
  assign out_tri = tri_r;

endmodule

FILE: sv/triangle_plane_clipper_top.sv
// Triangle clipper against a plane given by per-vertex signed distances.
// Input: drive the three vertices (x, y, z, dist, Q16.16) and raise start;
// an item is taken on a clock edge with start high and busy low. A vertex
// is inside when its distance is above zero.
// Output: zero, one or three triangles per item, each on the out_ ports for
// one cycle with out_valid high; out_last_tri marks the final one.
// Items with no inside vertex give nothing.
// An item with all vertices inside skips the split units. A cut item, once
// taken, passes operand latch, multiply, add and a 33-step restoring divide,
// then gives its triangles one per cycle. The back end works on one item at
// a time and pops the next only after the last triangle of the current one,
// so cut items are paced by the divider loop; uncut items skip it.
// A two-entry queue sits between the classifier and the back end, so
// input is taken while earlier items are still being split; busy is high
// when the queue is full.
// Reset (rst_n low, synchronous) empties the queue and stops output.
// The receiver cannot stall; results are never held.
module triangle_plane_clipper_top #(
  parameter int unsigned QUEUE_DEPTH = tpc_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_p_x,
  input  logic [31:0] in_p_y,
  input  logic [31:0] in_p_z,
  input  logic [31:0] in_p_dist,
  input  logic [31:0] in_q_x,
  input  logic [31:0] in_q_y,
  input  logic [31:0] in_q_z,
  input  logic [31:0] in_q_dist,
  input  logic [31:0] in_r_x,
  input  logic [31:0] in_r_y,
  input  logic [31:0] in_r_z,
  input  logic [31:0] in_r_dist,
  output logic        out_valid,
  output logic [31:0] out_a_x,
  output logic [31:0] out_a_y,
  output logic [31:0] out_a_z,
  output logic [31:0] out_b_x,
  output logic [31:0] out_b_y,
  output logic [31:0] out_b_z,
  output logic [31:0] out_c_x,
  output logic [31:0] out_c_y,
  output logic [31:0] out_c_z,
  output logic        out_last_tri
);

  tpc_pkg::vertex_t v0, v1, v2;
  tpc_pkg::job_t    job_w, job_q;
  tpc_pkg::tri_t    tri_w;
  logic             push, pop, empty, full;

  assign v0 = '{c: '{in_p_z, in_p_y, in_p_x}, d: in_p_dist};
  assign v1 = '{c: '{in_q_z, in_q_y, in_q_x}, d: in_q_dist};
  assign v2 = '{c: '{in_r_z, in_r_y, in_r_x}, d: in_r_dist};

  tpc_front u_front (
    .start(start), .full(full), .v0(v0), .v1(v1), .v2(v2),
    .push(push), .job(job_w)
  );

  tpc_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .wdata(job_w),
    .pop(pop), .rdata(job_q), .empty(empty), .full(full)
  );

  tpc_back u_back (
    .clk(clk), .rst_n(rst_n), .empty(empty), .job_in(job_q),
    .pop(pop), .out_vld(out_valid), .out_tri(tri_w)
  );

  assign busy         = full;
  assign out_a_x      = tri_w.c0[0];
  assign out_a_y      = tri_w.c0[1];
  assign out_a_z      = tri_w.c0[2];
  assign out_b_x      = tri_w.c1[0];
  assign out_b_y      = tri_w.c1[1];
  assign out_b_z      = tri_w.c1[2];
  assign out_c_x      = tri_w.c2[0];
  assign out_c_y      = tri_w.c2[1];
  assign out_c_z      = tri_w.c2[2];
  assign out_last_tri = tri_w.last;

`ifndef SYNTHESIS
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output strobe after reset");
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_tri |=> out_valid)
    else $error("gap inside a triangle burst");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue popped while empty");
`endif

endmodule

FILE: dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] ax, ay, az, bx, by, bz, cx, cy, cz;
    logic        last;
  } tri_exp_t;

  typedef struct {
    logic signed [31:0] x, y, z, d;
  } vert_t;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [31:0] in_p_x = 0, in_p_y = 0, in_p_z = 0, in_p_dist = 0;
  logic [31:0] in_q_x = 0, in_q_y = 0, in_q_z = 0, in_q_dist = 0;
  logic [31:0] in_r_x = 0, in_r_y = 0, in_r_z = 0, in_r_dist = 0;
  logic out_valid, out_last_tri;
  logic [31:0] out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z;
  logic [31:0] out_c_x, out_c_y, out_c_z;

  tri_exp_t tri_q[$];
  int mismatches = 0;
  int tri_seen = 0;
  int items_sent = 0;
  longint cycles = 0;

  triangle_plane_clipper_top u_top (.*);

  initial forever #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic signed [31:0] lerp_axis(logic signed [31:0] pi,
      logic signed [31:0] pj, logic signed [31:0] di, logic signed [31:0] dj);
    logic signed [63:0] diff, den;
    logic [127:0] mag, num, q;
    logic signed [63:0] r;
    den = 64'(di) - 64'(dj);
    diff = 64'(pj) - 64'(pi);
    mag = diff < 0 ? 128'(-diff) : 128'(diff);
    num = mag * 128'(di);
    q = (num + 128'(den) / 2) / 128'(den);
    r = diff < 0 ? 64'(pi) - 64'(q) : 64'(pi) + 64'(q);
    return r[31:0];
  endfunction

  function automatic vert_t cut_point(vert_t a, vert_t b);
    vert_t r;
    r.x = lerp_axis(a.x, b.x, a.d, b.d);
    r.y = lerp_axis(a.y, b.y, a.d, b.d);
    r.z = lerp_axis(a.z, b.z, a.d, b.d);
    r.d = 0;
    return r;
  endfunction

  function automatic logic [31:0] half_sum(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    return s[32:1];
  endfunction

  function automatic void push_tri(vert_t a, vert_t b, vert_t c, logic last);
    tri_exp_t t;
    t.ax = a.x; t.ay = a.y; t.az = a.z;
    t.bx = b.x; t.by = b.y; t.bz = b.z;
    t.cx = c.x; t.cy = c.y; t.cz = c.z;
    t.last = last;
    tri_q.insert(tri_q.size(), t);
  endfunction

  function automatic void predict_clip(vert_t v[3]);
    int n_in, k_in, k_out;
    vert_t a, b, o, va, vb, m;
    n_in = 0; k_in = 0; k_out = 0;
    for (int i = 0; i < 3; i++)
      if (v[i].d > 0) begin
        n_in++; k_in = i;
      end else k_out = i;
    if (n_in == 3) push_tri(v[0], v[1], v[2], 1'b1);
    else if (n_in == 1)
      push_tri(v[k_in], cut_point(v[k_in], v[(k_in + 1) % 3]),
               cut_point(v[k_in], v[(k_in + 2) % 3]), 1'b1);
    else if (n_in == 2) begin
      o = v[k_out]; a = v[(k_out + 2) % 3]; b = v[(k_out + 1) % 3];
      va = cut_point(a, o);
      vb = cut_point(b, o);
      m.x = half_sum(a.x, b.x); m.y = half_sum(a.y, b.y); m.z = half_sum(a.z, b.z);
      m.d = 0;
      push_tri(a, va, m, 1'b0);
      push_tri(m, va, vb, 1'b0);
      push_tri(m, vb, b, 1'b1);
    end
  endfunction

  always @(posedge clk) begin
    tri_exp_t e;
    if (rst_n && out_valid) begin
      tri_seen++;
      if (tri_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected triangle at cycle %0d", cycles);
      end else begin
        e = tri_q.pop_front();
        if ({out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z, out_c_x, out_c_y,
             out_c_z, out_last_tri} !== {e.ax, e.ay, e.az, e.bx, e.by, e.bz, e.cx,
             e.cy, e.cz, e.last}) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp a=%h %h %h b=%h %h %h c=%h %h %h l=%b",
                     e.ax, e.ay, e.az, e.bx, e.by, e.bz, e.cx, e.cy, e.cz, e.last);
            $display("          got a=%h %h %h b=%h %h %h c=%h %h %h l=%b",
                     out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z,
                     out_c_x, out_c_y, out_c_z, out_last_tri);
          end
        end
      end
    end
  end

  int burst_left = 0;

  task automatic send_tri(vert_t v[3]);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        start <= 0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1;
    in_p_x <= v[0].x; in_p_y <= v[0].y; in_p_z <= v[0].z; in_p_dist <= v[0].d;
    in_q_x <= v[1].x; in_q_y <= v[1].y; in_q_z <= v[1].z; in_q_dist <= v[1].d;
    in_r_x <= v[2].x; in_r_y <= v[2].y; in_r_z <= v[2].z; in_r_dist <= v[2].d;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_clip(v);
    items_sent++;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 8) - 4;
      3: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_dist();
    case ($urandom_range(0, 6))
      0: return 0;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      3: return $urandom_range(1, 3);
      4: return -$urandom_range(1, 3);
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    start <= 0;
    while (tri_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic test_directed();
    vert_t v[3];
    logic [31:0] ext[4] = '{32'h8000_0000, 32'h7fff_ffff, 0, 32'hffff_ffff};
    for (int mask = 0; mask < 8; mask++)
      for (int e = 0; e < 2; e++) begin
        for (int i = 0; i < 3; i++) begin
          v[i].x = ext[(i + e) % 4]; v[i].y = ext[(i + e + 1) % 4];
          v[i].z = ext[(i + 2 * e) % 4];
          v[i].d = mask[i] ? (e ? 32'h7fff_ffff : 32'd1) : (e ? 32'h8000_0000 : 32'd0);
        end
        send_tri(v);
      end
    // distance of -1 beside +1, and ties in rounding
    v[0] = '{x: 0, y: 32'h0001_0000, z: 3, d: 1};
    v[1] = '{x: 1, y: -32'sd1, z: -3, d: -1};
    v[2] = '{x: 32'h7fff_ffff, y: 32'h8000_0000, z: 5, d: 2};
    send_tri(v);
    v[2].d = -3;
    send_tri(v);
    wait_drained();
  endtask

  task automatic test_random();
    vert_t v[3];
    for (int n = 0; n < 370; n++) begin
      for (int i = 0; i < 3; i++) begin
        v[i].x = rand_word(); v[i].y = rand_word(); v[i].z = rand_word();
        v[i].d = rand_dist();
      end
      send_tri(v);
      if (n == 180) wait_drained();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_random();
    wait_drained();
    $display("sent %0d triangles, checked %0d clipped triangles", items_sent, tri_seen);
    if (mismatches == 0 && tri_q.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

FILE: sim.f
sv/tpc_pkg.sv
sv/tpc_front.sv
sv/tpc_fifo.sv
sv/tpc_split.sv
sv/tpc_back.sv
sv/triangle_plane_clipper_top.sv
dv/testbench.sv
